// ----- hw/rtl/kai_pkg.sv -----
package kai_pkg;

	// Request codes.
	localparam logic [2:0] REQ_CLEAR = 3'd0;
	localparam logic [2:0] REQ_ADD   = 3'd1;
	localparam logic [2:0] REQ_RESET = 3'd2;
	localparam logic [2:0] REQ_TICK  = 3'd3;
	localparam logic [2:0] REQ_SET   = 3'd4;

	// Pi and two pi in Q8.24.
	localparam logic [32:0] SK_PI      = 33'd52707179;
	localparam logic [32:0] TWO_PI_Q24 = 33'd105414357;

	// Divider request and result.
	typedef struct packed {
		logic        start;
		logic [32:0] dividend;
		logic [23:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [32:0] quotient;
	} div_rsp_t;

	// Sign-extend a Q3.13 angle to Q8.24.
	function automatic logic signed [31:0] q13_to_q24(input logic [15:0] raw);
		q13_to_q24 = {{5{raw[15]}}, raw, 11'd0};
	endfunction

endpackage

// ----- hw/rtl/keyframe_angle_interpolator_core.sv -----
// Keyframe angle interpolator; one request is in flight at a time.
// Clear, set angle, unused codes, ticks mid-segment or keyless, a full-table add and a reset with
// under two keys go straight to the output register; other resets and boundary ticks first read
// the segment's keyframes, a segment-starting tick also runs the bit-serial divider, and other adds
// search and shift the table. A result waiting in the output register holds the next request only
// at its final step. Reset clears all control state; table contents stay undefined until written.
module keyframe_angle_interpolator_core #(
	parameter int MAX_KEYS   = 16,
	parameter int FRAME_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // key_frame[15:0], angle_value[31:16]
	input  logic [2:0]  s_tuser,  // req_type[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // angle[31:0], frame_count[47:32]
	output logic [1:0]  m_tuser   // animating[0], status[1]
);

	localparam int IW = $clog2(MAX_KEYS + 1);
	localparam int AW = $clog2(MAX_KEYS);
	localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_SRCH  = 10'b0000000010,
		ST_SRCHW = 10'b0000000100,
		ST_SHR   = 10'b0000001000,
		ST_SHW   = 10'b0000010000,
		ST_RDS   = 10'b0000100000,
		ST_RDE   = 10'b0001000000,
		ST_CALC  = 10'b0010000000,
		ST_DIV   = 10'b0100000000,
		ST_OUT   = 10'b1000000000
	} state_t;

	state_t state_q;

	// Keyframe table: frame in the upper half, Q3.13 angle in the lower half.
	logic [31:0] mem [MAX_KEYS];
	logic [31:0] rd_q;
	logic        mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [31:0] mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	logic [IW-1:0] kcnt_q, kidx_q, sptr_q, eptr_q, pos_q, shi_q;
	logic [1:0]  pv_q;
	logic [FRAME_BITS-1:0] fc_q;
	logic signed [17:0] fl_q;
	logic signed [31:0] inc_q, acc_q;
	logic [2:0]  req_q;
	logic [15:0] kf_q, av_q;
	logic [31:0] sent_q;
	logic        neg_q, st_q;
	logic        rew_q;
	logic        full_q;
	logic        out_load;

	logic [2:0]  req_in;
	logic [15:0] kf_in, av_in;
	assign req_in = s_tuser;
	assign kf_in  = s_tdata[15:0];
	assign av_in  = s_tdata[31:16];

	kai_pkg::div_req_t dreq;
	kai_pkg::div_rsp_t drsp;
	kai_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	assign s_tready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_OUT) && (!full_q || m_tready);

	// Shortest-arc difference between start and end angles.
	logic signed [32:0] sa, ea, diff;
	logic [32:0] mag, magw, mabs;
	logic        negw, negf;
	logic [FRAME_BITS-1:0] ef, sfw;
	logic [23:0] span;
	logic        seg_go;
	assign sa   = 33'(kai_pkg::q13_to_q24(sent_q[15:0]));
	assign ea   = 33'(kai_pkg::q13_to_q24(rd_q[15:0]));
	assign diff = ea - sa;
	assign mag  = diff[32] ? 33'(-diff) : diff;
	assign ef   = FRAME_BITS'(rd_q[31:16]);
	assign sfw  = FRAME_BITS'(sent_q[31:16]);
	always_comb begin
		if (mag > kai_pkg::SK_PI) begin
			magw = kai_pkg::TWO_PI_Q24 - mag;
			negw = !diff[32] && (diff != 0);
		end else begin
			magw = mag;
			negw = diff[32];
		end
		span = (ef < sfw) ? 24'd0 : 24'(ef - sfw);
	end

	// The wrapped magnitude can go negative; divide its size and fold the sign in.
	assign mabs   = magw[32] ? 33'(-magw) : magw;
	assign negf   = negw ^ magw[32];
	assign seg_go = (pv_q == 2'b11) && (fc_q >= sfw);

	// Table port address and write data, and the divider request.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = AW'(pos_q);
		mem_wd = {kf_q, av_q};
		mem_ra = AW'(pos_q);
		dreq.start    = 1'b0;
		dreq.dividend = mabs;
		dreq.divisor  = span;
		case (state_q)
			ST_SHR: mem_ra = AW'(shi_q - IW'(1));
			ST_SHW: begin
				mem_we = 1'b1;
				mem_wa = AW'(shi_q);
				mem_wd = rd_q;
			end
			ST_RDS: mem_ra = AW'(sptr_q);
			ST_RDE: mem_ra = AW'(eptr_q);
			ST_CALC: dreq.start = (req_q == kai_pkg::REQ_TICK) && seg_go && (span != 0);
			default: ;
		endcase
		if (state_q == ST_SHR && shi_q == pos_q) mem_we = 1'b1;
	end

	// Frame counter step, saturating.
	function automatic logic [FRAME_BITS-1:0] fc_next(input logic [FRAME_BITS-1:0] f);
		fc_next = (f < FRAME_MAX) ? f + FRAME_BITS'(1) : f;
	endfunction

	logic signed [32:0] sum;
	assign sum = 33'(acc_q) + 33'(inc_q);

	// Request sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kcnt_q <= '0; kidx_q <= '0; sptr_q <= '0; eptr_q <= '0; pos_q <= '0;
			shi_q <= '0;
			pv_q <= '0; fc_q <= '0; fl_q <= '0; inc_q <= '0; acc_q <= '0;
			full_q <= 1'b0; st_q <= 1'b0; req_q <= '0; rew_q <= 1'b0;
		end else begin
			if (out_load) full_q <= 1'b1;
			else if (m_tready) full_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (s_tvalid && s_tready) begin
					req_q <= req_in;
					kf_q <= kf_in;
					av_q <= av_in;
					st_q <= 1'b0;
					state_q <= ST_OUT;
					case (req_in)
						kai_pkg::REQ_CLEAR: begin
							kcnt_q <= '0; kidx_q <= '0; sptr_q <= '0; eptr_q <= '0;
							pv_q <= '0; fl_q <= '0; inc_q <= '0;
						end
						kai_pkg::REQ_ADD: begin
							if (32'(kcnt_q) >= MAX_KEYS) st_q <= 1'b1;
							else begin
								pos_q <= '0;
								state_q <= ST_SRCH;
							end
						end
						kai_pkg::REQ_RESET: begin
							inc_q <= '0; fc_q <= '0; fl_q <= '0; sptr_q <= '0;
							if (kcnt_q >= IW'(2)) begin
								eptr_q <= IW'(1); kidx_q <= IW'(1); pv_q <= 2'b11;
								state_q <= ST_RDS;
							end else begin
								eptr_q <= '0; kidx_q <= '0; pv_q <= '0;
							end
						end
						kai_pkg::REQ_TICK: begin
							if (kcnt_q != 0) begin
								if (fl_q > 0) begin
									if (sum > 33'sd2147483647) acc_q <= 32'h7fffffff;
									else if (sum < -33'sd2147483648) acc_q <= 32'h80000000;
									else acc_q <= sum[31:0];
									fl_q <= fl_q - 18'sd1;
								end
								if (fl_q == 1 || fl_q == 0) begin
									// No valid pointers: rewind to the first segment.
									if (pv_q == 2'b00) begin
										inc_q <= '0; fc_q <= '0; sptr_q <= '0;
										if (kcnt_q >= IW'(2)) begin
											eptr_q <= IW'(1); kidx_q <= IW'(1);
											pv_q <= 2'b11;
											rew_q <= 1'b1;
										end else begin
											eptr_q <= '0; kidx_q <= '0;
										end
									end
									state_q <= ST_RDS;
								end else fc_q <= fc_next(fc_q);
							end
						end
						kai_pkg::REQ_SET: acc_q <= kai_pkg::q13_to_q24(av_in);
						default: ;
					endcase
				end
				// Find the insertion point: first entry with a larger frame.
				ST_SRCH: begin
					if (pos_q == kcnt_q) begin
						shi_q <= kcnt_q;
						state_q <= ST_SHR;
					end else state_q <= ST_SRCHW;
				end
				ST_SRCHW: begin
					if (rd_q[31:16] > kf_q) begin
						shi_q <= kcnt_q;
						state_q <= ST_SHR;
					end else begin
						pos_q <= pos_q + IW'(1);
						state_q <= ST_SRCH;
					end
				end
				// Move entries up one place from the top down to the insertion point.
				ST_SHR: begin
					if (shi_q == pos_q) begin
						kcnt_q <= kcnt_q + IW'(1);
						state_q <= ST_OUT;
					end else state_q <= ST_SHW;
				end
				ST_SHW: begin
					shi_q <= shi_q - IW'(1);
					state_q <= ST_SHR;
				end
				ST_RDS: state_q <= ST_RDE;
				ST_RDE: begin
					sent_q <= rd_q;
					state_q <= ST_CALC;
				end
				// Segment boundary: compute the new increment.
				ST_CALC: begin
					neg_q <= negf;
					inc_q <= '0;
					if (req_q != kai_pkg::REQ_TICK) begin
						// Reset animation starts from the first keyframe's angle.
						acc_q <= sa[31:0];
						fl_q <= '0;
						state_q <= ST_OUT;
					end else begin
						if (rew_q) acc_q <= sa[31:0];
						if (seg_go) begin
							fl_q <= 18'(span);
							state_q <= (span != 0) ? ST_DIV : ST_OUT;
						end else begin
							fl_q <= (pv_q == 2'b11) ? 18'sd0 : -18'sd1;
							state_q <= ST_OUT;
						end
						fc_q <= fc_next(fc_q);
						// Advance the pointers unless the start keyframe is still ahead.
						if (!(pv_q[0] && fc_q < sfw)) begin
							sptr_q <= eptr_q;
							if (kidx_q + IW'(1) < kcnt_q) begin
								kidx_q <= kidx_q + IW'(1);
								eptr_q <= kidx_q + IW'(1);
								pv_q <= {1'b1, pv_q[1]};
							end else pv_q <= {1'b0, pv_q[1]};
						end
					end
				end
				ST_DIV: if (drsp.done) begin
					inc_q <= neg_q ? 32'(-drsp.quotient) : drsp.quotient[31:0];
					state_q <= ST_OUT;
				end
				ST_OUT: if (out_load) begin
					rew_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	logic [31:0] oa_q;
	logic [15:0] of_q;
	logic        oan_q, ost_q;
	always_ff @(posedge clk) begin
		if (out_load) begin
			oa_q <= acc_q;
			of_q <= 16'(fc_q);
			oan_q <= fl_q > 0;
			ost_q <= st_q;
		end
	end

	assign m_tvalid = full_q;
	assign m_tdata  = {of_q, oa_q};
	assign m_tuser  = {ost_q, oan_q};

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != ST_IDLE) else $error("accept not started");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(kcnt_q) <= MAX_KEYS) else $error("key count overflow");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result lost");

endmodule

// ----- hw/rtl/kai_div.sv -----
// Restoring divider, one quotient bit per cycle.
module kai_div (
	input  logic              clk,
	input  logic              arst_n,
	input  kai_pkg::div_req_t req,
	output kai_pkg::div_rsp_t rsp
);

	logic [32:0] quo_q;
	logic [23:0] rem_q;
	logic [23:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [24:0] trial;

	assign trial = {rem_q, quo_q[32]} - {1'b0, dvs_q};

	// Shift in one dividend bit per cycle and try the subtraction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!trial[24]) begin
				rem_q <= trial[23:0];
				quo_q <= {quo_q[31:0], 1'b1};
			end else begin
				rem_q <= {rem_q[22:0], quo_q[32]};
				quo_q <= {quo_q[31:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- sim/keyframe_angle_interpolator_core_test.sv -----
module keyframe_angle_interpolator_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REQ_UNUSED = 3'd5;
	localparam logic [2:0] REQ_SPARE = 3'd7;
	localparam logic [1:0] START_OK = 2'b01;
	localparam logic [1:0] END_OK = 2'b10;
	localparam int TABLE_DEPTH = 16;
	localparam int FRAME_TOP = 65535;
	localparam int RANDOM_ITEMS = 1650;
	localparam int LONG_TICKS = 100;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic signed [31:0] angle;
		logic [15:0]        frame_count;
		logic               animating;
		logic               status;
	} pose_t;

	typedef struct {
		logic [2:0]  req;
		logic [15:0] key_frame;
		logic [15:0] angle_value;
		bit          known;
		pose_t       pose;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // key_frame[15:0], angle_value[31:16]
	logic [2:0]  s_tuser;   // req_type[2:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // angle[31:0], frame_count[47:32]
	logic [1:0]  m_tuser;   // animating[0], status[1]

	keyframe_angle_interpolator_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// Shadow copy of the interpolator state.
	logic [31:0] key_mem [TABLE_DEPTH];
	int          key_total;
	int          key_pos;
	int          seg_start;
	int          seg_end;
	logic [1:0]  seg_valid;
	int          frame_now;
	int          frames_to_go;
	int          frame_step;
	int          angle_now;

	pose_t pending_poses[$];
	int    mismatches;
	bit    gaps_on;
	int    hold_token;
	int    burst_left;

	function automatic int key_frame_at(int i);
		return int'(key_mem[i][31:16]);
	endfunction

	function automatic int key_angle_at(int i);
		logic [31:0] wide;
		wide = {{5{key_mem[i][15]}}, key_mem[i][15:0], 11'd0};
		return int'(signed'(wide));
	endfunction

	function automatic int widen_q13(logic [15:0] raw);
		logic [31:0] wide;
		wide = {{5{raw[15]}}, raw, 11'd0};
		return int'(signed'(wide));
	endfunction

	function automatic void bump_frame();
		if (frame_now < FRAME_TOP) frame_now++;
	endfunction

	function automatic void rewind_animation();
		frame_step = 0;
		frame_now = 0;
		key_pos = 0;
		frames_to_go = 0;
		seg_start = 0;
		if (key_total >= 2) begin
			seg_end = 1;
			key_pos = 1;
			seg_valid = START_OK | END_OK;
			angle_now = key_angle_at(0);
		end else begin
			seg_end = 0;
			seg_valid = '0;
		end
	endfunction

	// Work out the increment for the segment between the two pointers.
	function automatic void open_segment();
		longint diff, mag;
		int     span;
		bit     neg;
		if (seg_valid == '0) rewind_animation();
		if (seg_valid == (START_OK | END_OK) && frame_now >= key_frame_at(seg_start)) begin
			diff = longint'(key_angle_at(seg_end)) - longint'(key_angle_at(seg_start));
			mag = diff < 0 ? -diff : diff;
			span = key_frame_at(seg_end) - key_frame_at(seg_start);
			if (span < 0) span = 0;
			// Take the shorter way around the circle.
			if (mag > longint'(kai_pkg::SK_PI)) begin
				mag = longint'(kai_pkg::TWO_PI_Q24) - mag;
				neg = diff > 0;
			end else begin
				neg = diff < 0;
			end
			frames_to_go = span;
			if (span == 0) frame_step = 0;
			else frame_step = neg ? int'(-(mag / span)) : int'(mag / span);
		end else if (seg_valid == (START_OK | END_OK)) begin
			frames_to_go = 0;
			frame_step = 0;
		end else begin
			frames_to_go = -1;
			frame_step = 0;
		end
	endfunction

	function automatic void advance_frame();
		longint sum;
		if (key_total == 0) return;
		if (frames_to_go > 0) begin
			sum = longint'(angle_now) + longint'(frame_step);
			if (sum > 64'sd2147483647) sum = 64'sd2147483647;
			if (sum < -64'sd2147483648) sum = -64'sd2147483648;
			angle_now = int'(sum);
			frames_to_go--;
		end
		if (frames_to_go == 0) begin
			open_segment();
			// A start keyframe still ahead of the counter holds the segment.
			if (seg_valid[0] && frame_now < key_frame_at(seg_start)) begin
				bump_frame();
				return;
			end
			seg_start = seg_end;
			seg_valid = seg_valid[1] ? START_OK : 2'b00;
			if (key_pos + 1 < key_total) begin
				key_pos++;
				seg_end = key_pos;
				seg_valid |= END_OK;
			end
		end
		bump_frame();
	endfunction

	function automatic bit insert_key(logic [15:0] kf, logic [15:0] ang);
		int slot;
		if (key_total >= TABLE_DEPTH) return 1'b0;
		slot = 0;
		while (slot < key_total && key_frame_at(slot) <= int'(kf)) slot++;
		for (int j = key_total; j > slot; j--) key_mem[j] = key_mem[j - 1];
		key_mem[slot] = {kf, ang};
		key_total++;
		return 1'b1;
	endfunction

	function automatic pose_t predict_pose(logic [2:0] req, logic [15:0] kf, logic [15:0] ang);
		pose_t p;
		p.status = 1'b0;
		case (req)
			kai_pkg::REQ_CLEAR: begin
				key_total = 0;
				key_pos = 0;
				seg_start = 0;
				seg_end = 0;
				seg_valid = '0;
				frames_to_go = 0;
				frame_step = 0;
			end
			kai_pkg::REQ_ADD: p.status = !insert_key(kf, ang);
			kai_pkg::REQ_RESET: rewind_animation();
			kai_pkg::REQ_TICK: advance_frame();
			kai_pkg::REQ_SET: angle_now = widen_q13(ang);
			default: ;
		endcase
		p.angle = angle_now;
		p.frame_count = frame_now[15:0];
		p.animating = frames_to_go > 0;
		return p;
	endfunction

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	longint cycle_count;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result side: check each accepted result against the oldest prediction.
	always @(posedge clk) begin
		pose_t want;
		pose_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[31:0], m_tdata[47:32], m_tuser[0], m_tuser[1]};
			if (pending_poses.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: angle %0d frame %0d anim %0b status %0b",
						got.angle, got.frame_count, got.animating, got.status);
			end else begin
				want = pending_poses.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp angle %0d frame %0d anim %0b status %0b, ",
							"got angle %0d frame %0d anim %0b status %0b"},
							want.angle, want.frame_count, want.animating, want.status,
							got.angle, got.frame_count, got.animating, got.status);
				end
			end
		end
	end

	// Receiver stall pattern, with one long hold counted here.
	int hold_seen;
	int hold_left;
	int stall_phase;
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= 400;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (!gaps_on) begin
			m_tready <= 1'b1;
		end else begin
			case ((stall_phase / 64) % 3)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Offer one request, wait until taken; valid stays high unless a gap is due.
	task automatic send_request(logic [2:0] req, logic [15:0] kf, logic [15:0] ang,
			bit known, pose_t typed);
		pose_t p;
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {ang, kf};
		do @(posedge clk); while (!s_tready);
		p = predict_pose(req, kf, ang);
		pending_poses.insert(pending_poses.size(), known ? typed : p);
		if (gaps_on) begin
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(0, 20);
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic drive(logic [2:0] req, logic [15:0] kf, logic [15:0] ang);
		send_request(req, kf, ang, 1'b0, '0);
	endtask

	// Let the block drain before the next phase.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_frame();
		return ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 30));
	endfunction

	// One animation: load keys, rewind, then tick through it with some noise.
	task automatic play_sequence(output int used);
		int n_keys;
		int n_ticks;
		used = 0;
		if ($urandom_range(0, 3) != 0) begin
			drive(kai_pkg::REQ_CLEAR, 16'($urandom), 16'($urandom));
			used++;
		end
		n_keys = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
		repeat (n_keys) begin
			drive(kai_pkg::REQ_ADD, pick_frame(), 16'($urandom));
			used++;
		end
		drive(kai_pkg::REQ_RESET, 16'($urandom), 16'($urandom));
		used++;
		n_ticks = $urandom_range(5, 70);
		repeat (n_ticks) begin
			case ($urandom_range(0, 19))
				0: drive(kai_pkg::REQ_ADD, pick_frame(), 16'($urandom));
				1: drive(kai_pkg::REQ_SET, 16'($urandom), 16'($urandom));
				2: drive(3'($urandom), 16'($urandom), 16'($urandom));
				default: drive(kai_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
			endcase
			used++;
		end
	endtask

	row_t steps[$];

	function automatic void stage_row(row_t r);
		steps.insert(steps.size(), r);
	endfunction

	function automatic row_t mk(logic [2:0] req, logic [15:0] kf, logic [15:0] ang,
			bit known = 1'b0, int ang_out = 0, int fr = 0);
		row_t r;
		r.req = req;
		r.key_frame = kf;
		r.angle_value = ang;
		r.known = known;
		r.pose = '{angle: ang_out, frame_count: fr[15:0], animating: 1'b0, status: 1'b0};
		return r;
	endfunction

	initial begin
		int sent;
		int used;
		bit held;
		bit paused;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		arst_n = 1'b0;
		cycle_count = 0;
		mismatches = 0;
		hold_token = 0;
		hold_seen = 0;
		hold_left = 0;
		stall_phase = 0;
		burst_left = 0;
		gaps_on = 1'b1;
		key_total = 0;
		key_pos = 0;
		seg_start = 0;
		seg_end = 0;
		seg_valid = '0;
		frame_now = 0;
		frames_to_go = 0;
		frame_step = 0;
		angle_now = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows: extremes, every request, and the named corner cases.
		stage_row(mk(kai_pkg::REQ_TICK, 16'hFFFF, 16'hFFFF, 1'b1, 0, 0));
		stage_row(mk(kai_pkg::REQ_SET, 16'h0000, 16'h7FFF, 1'b1, 67106816, 0));
		stage_row(mk(REQ_UNUSED, 16'hFFFF, 16'h8000, 1'b1, 67106816, 0));
		stage_row(mk(REQ_SPARE, 16'hFFFF, 16'hFFFF, 1'b1, 67106816, 0));
		stage_row(mk(kai_pkg::REQ_SET, 16'hFFFF, 16'h8000, 1'b1, -67108864, 0));
		stage_row(mk(kai_pkg::REQ_CLEAR, 16'h0000, 16'h0000, 1'b1, -67108864, 0));
		stage_row(mk(kai_pkg::REQ_ADD, 16'hFFFF, 16'h7FFF, 1'b1, -67108864, 0));
		stage_row(mk(kai_pkg::REQ_ADD, 16'h0000, 16'h8000, 1'b1, -67108864, 0));
		stage_row(mk(kai_pkg::REQ_ADD, 16'h0000, 16'h1000));
		stage_row(mk(kai_pkg::REQ_RESET, 16'h0000, 16'h0000));
		stage_row(mk(kai_pkg::REQ_TICK, 16'h0000, 16'h0000));
		stage_row(mk(kai_pkg::REQ_TICK, 16'h0000, 16'h0000));
		stage_row(mk(kai_pkg::REQ_TICK, 16'h0000, 16'h0000));
		stage_row(mk(kai_pkg::REQ_ADD, 16'h0003, 16'h6000));
		stage_row(mk(kai_pkg::REQ_TICK, 16'h0000, 16'h0000));
		stage_row(mk(kai_pkg::REQ_CLEAR, 16'h0000, 16'h0000));
		stage_row(mk(kai_pkg::REQ_ADD, 16'h0005, 16'h6000));
		stage_row(mk(kai_pkg::REQ_ADD, 16'h0005, 16'hA000));
		stage_row(mk(kai_pkg::REQ_ADD, 16'h0008, 16'h2000));
		stage_row(mk(kai_pkg::REQ_RESET, 16'h0000, 16'h0000));
		for (int i = 0; i < 5; i++) stage_row(mk(kai_pkg::REQ_TICK, 16'h0000, 16'h0000));
		foreach (steps[i])
			send_request(steps[i].req, steps[i].key_frame, steps[i].angle_value,
				steps[i].known, steps[i].pose);
		settle();

		// Random animations, with one long output hold and one full drain.
		sent = 0;
		held = 1'b0;
		paused = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (!held && sent > 300) begin
				held = 1'b1;
				hold_token++;
			end
			if (!paused && sent > 900) begin
				paused = 1'b1;
				settle();
			end
			play_sequence(used);
			sent += used;
		end
		settle();

		// A single keyframe, then a run of ticks past the end of the animation.
		gaps_on = 1'b0;
		drive(kai_pkg::REQ_CLEAR, 16'h0000, 16'h0000);
		drive(kai_pkg::REQ_ADD, 16'h0002, 16'h4000);
		drive(kai_pkg::REQ_RESET, 16'h0000, 16'h0000);
		repeat (LONG_TICKS) drive(kai_pkg::REQ_TICK, 16'($urandom), 16'($urandom));
		s_tvalid <= 1'b0;
		@(posedge clk);

		while (pending_poses.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- keyframe_angle_interpolator_core.f -----
hw/rtl/kai_pkg.sv
hw/rtl/kai_div.sv
hw/rtl/keyframe_angle_interpolator_core.sv
sim/keyframe_angle_interpolator_core_test.sv
